// ===== hdl/bqlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared constants, sequencer step codes and the control bundle of the
// biquad low-pass filter.
// ----------------------------------------------------------------------------
package bqlp_pkg;

   localparam int STATE_FRAC = 8;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B0     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B1     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A1     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A2     = 3'd5;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
   localparam logic [STEP_W-1:0] ST_A1   = 4'd1;
   localparam logic [STEP_W-1:0] ST_A2   = 4'd2;
   localparam logic [STEP_W-1:0] ST_SUBW = 4'd3;
   localparam logic [STEP_W-1:0] ST_CHK  = 4'd4;
   localparam logic [STEP_W-1:0] ST_B0   = 4'd5;
   localparam logic [STEP_W-1:0] ST_B1   = 4'd6;
   localparam logic [STEP_W-1:0] ST_B2   = 4'd7;
   localparam logic [STEP_W-1:0] ST_SUMY = 4'd8;
   localparam logic [STEP_W-1:0] ST_DONE = 4'd9;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              start;
      logic              commit;
      logic              bypass;
   } ctrl_type;

endpackage

// ===== hdl/bqlp_if.sv =====
// ----------------------------------------------------------------------------
// bqlp_if
// Valid/ready channels for the sample beats going into and out of the filter.
// ----------------------------------------------------------------------------
interface bqlp_req_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqlp_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           bad_value;

   modport source (output valid, output sample_out, output bad_value, input ready);
   modport sink   (input valid, input sample_out, input bad_value, output ready);
endinterface

// ===== hdl/bqlp_csr.sv =====
// ----------------------------------------------------------------------------
// bqlp_csr
// Configuration registers: filter enable and the five biquad coefficients.
// ----------------------------------------------------------------------------
module bqlp_csr #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bqlp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [COEF_WIDTH-1:0]               csr_wdata,
   output logic                                enable,
   output logic signed [COEF_WIDTH-1:0]        coef_b0,
   output logic signed [COEF_WIDTH-1:0]        coef_b1,
   output logic signed [COEF_WIDTH-1:0]        coef_b2,
   output logic signed [COEF_WIDTH-1:0]        coef_a1,
   output logic signed [COEF_WIDTH-1:0]        coef_a2
);

   logic                         enable_ff;
   logic signed [COEF_WIDTH-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         b0_ff     <= '0;
         b1_ff     <= '0;
         b2_ff     <= '0;
         a1_ff     <= '0;
         a2_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bqlp_pkg::REG_ENABLE: enable_ff <= csr_wdata[0];
            bqlp_pkg::REG_B0:     b0_ff     <= csr_wdata;
            bqlp_pkg::REG_B1:     b1_ff     <= csr_wdata;
            bqlp_pkg::REG_B2:     b2_ff     <= csr_wdata;
            bqlp_pkg::REG_A1:     a1_ff     <= csr_wdata;
            bqlp_pkg::REG_A2:     a2_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign enable  = enable_ff;
   assign coef_b0 = b0_ff;
   assign coef_b1 = b1_ff;
   assign coef_b2 = b2_ff;
   assign coef_a1 = a1_ff;
   assign coef_a2 = a2_ff;

endmodule

// ===== hdl/bqlp_seq.sv =====
// ----------------------------------------------------------------------------
// bqlp_seq
// Step sequencer: takes a sample beat, walks the shared multiplier through
// the five products if enabled, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bqlp_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                enable,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output bqlp_pkg::ctrl_type  ctrl
);

   logic [bqlp_pkg::STEP_W-1:0] state_ff, state_in;
   logic                        bypass_ff, bypass_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        start, commit;

   assign req_ready = (state_ff == bqlp_pkg::ST_IDLE);
   assign start     = req_valid && req_ready;
   assign commit    = (state_ff == bqlp_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      bypass_in = bypass_ff;
      case (state_ff)
         bqlp_pkg::ST_IDLE: begin
            if (start) begin
               bypass_in = !enable;
               state_in  = enable ? bqlp_pkg::ST_A1 : bqlp_pkg::ST_DONE;
            end
         end
         bqlp_pkg::ST_A1:   state_in = bqlp_pkg::ST_A2;
         bqlp_pkg::ST_A2:   state_in = bqlp_pkg::ST_SUBW;
         bqlp_pkg::ST_SUBW: state_in = bqlp_pkg::ST_CHK;
         bqlp_pkg::ST_CHK:  state_in = bqlp_pkg::ST_B0;
         bqlp_pkg::ST_B0:   state_in = bqlp_pkg::ST_B1;
         bqlp_pkg::ST_B1:   state_in = bqlp_pkg::ST_B2;
         bqlp_pkg::ST_B2:   state_in = bqlp_pkg::ST_SUMY;
         bqlp_pkg::ST_SUMY: state_in = bqlp_pkg::ST_DONE;
         bqlp_pkg::ST_DONE: begin
            if (commit) begin
               state_in = bqlp_pkg::ST_IDLE;
            end
         end
         default: state_in = bqlp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqlp_pkg::ST_IDLE;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign ctrl.step   = state_ff;
   assign ctrl.start  = start;
   assign ctrl.commit = commit;
   assign ctrl.bypass = bypass_ff;

endmodule

// ===== hdl/bqlp_dpath.sv =====
// ----------------------------------------------------------------------------
// bqlp_dpath
// Filter datapath: one shared multiplier with a product register, an
// accumulator, the two delay elements and the output register.
// ----------------------------------------------------------------------------
module bqlp_dpath #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16,
   parameter int STATE_WIDTH  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bqlp_pkg::ctrl_type               ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
   input  logic signed [COEF_WIDTH-1:0]     coef_b0,
   input  logic signed [COEF_WIDTH-1:0]     coef_b1,
   input  logic signed [COEF_WIDTH-1:0]     coef_b2,
   input  logic signed [COEF_WIDTH-1:0]     coef_a1,
   input  logic signed [COEF_WIDTH-1:0]     coef_a2,
   output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
   output logic                             bad_value
);

   localparam int FR     = bqlp_pkg::STATE_FRAC;
   localparam int CF     = COEF_WIDTH - 2;
   localparam int YSH    = FR + CF;
   localparam int DLY_W  = (STATE_WIDTH > SAMPLE_WIDTH + FR) ? STATE_WIDTH : SAMPLE_WIDTH + FR;
   localparam int PROD_W = DLY_W + COEF_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(1) <<< (CF - 1);
   localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) <<< (YSH - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [DLY_W-1:0]        d1_ff, d2_ff, w_ff, w_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic                           bad_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, y_sat;
   logic                           out_bad_ff;

   logic signed [COEF_WIDTH-1:0]   mul_coef;
   logic signed [DLY_W-1:0]        mul_data;
   logic signed [DLY_W-1:0]        x_state;
   logic signed [ACC_W-1:0]        acc_w_shift;
   logic [ACC_W-STATE_WIDTH-CF:0]  w_hi;
   logic [ACC_W-SAMPLE_WIDTH-YSH:0] y_hi;
   logic                           w_ovf;

   always_comb begin
      mul_coef = coef_a1;
      mul_data = d1_ff;
      case (ctrl.step)
         bqlp_pkg::ST_A1: begin
            mul_coef = coef_a1;
            mul_data = d1_ff;
         end
         bqlp_pkg::ST_A2: begin
            mul_coef = coef_a2;
            mul_data = d2_ff;
         end
         bqlp_pkg::ST_B0: begin
            mul_coef = coef_b0;
            mul_data = w_ff;
         end
         bqlp_pkg::ST_B1: begin
            mul_coef = coef_b1;
            mul_data = d1_ff;
         end
         bqlp_pkg::ST_B2: begin
            mul_coef = coef_b2;
            mul_data = d2_ff;
         end
         default: begin
            mul_coef = coef_a1;
            mul_data = d1_ff;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_coef) * PROD_W'(mul_data);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = (ACC_W'(sample_in) <<< YSH) + HALF_W;
      end else begin
         case (ctrl.step)
            bqlp_pkg::ST_A2,
            bqlp_pkg::ST_SUBW: acc_in = acc_ff - ACC_W'(prod_ff);
            bqlp_pkg::ST_B1:   acc_in = ACC_W'(prod_ff) + HALF_Y;
            bqlp_pkg::ST_B2,
            bqlp_pkg::ST_SUMY: acc_in = acc_ff + ACC_W'(prod_ff);
            default:           acc_in = acc_ff;
         endcase
      end
   end

   // The rounded internal value fits the state when every bit above its
   // sign position is a copy of the sign.
   assign x_state     = DLY_W'(x_ff) <<< FR;
   assign acc_w_shift = acc_ff >>> CF;
   assign w_hi        = acc_ff[ACC_W-1:STATE_WIDTH-1+CF];
   assign w_ovf       = !((&w_hi) || !(|w_hi));
   assign w_in        = w_ovf ? x_state : DLY_W'(acc_w_shift);

   assign y_hi = acc_ff[ACC_W-1:SAMPLE_WIDTH-1+YSH];
   always_comb begin
      if ((&y_hi) || !(|y_hi)) begin
         y_sat = acc_ff[SAMPLE_WIDTH-1+YSH:YSH];
      end else if (acc_ff[ACC_W-1]) begin
         y_sat = SAT_MIN;
      end else begin
         y_sat = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctrl.commit && !ctrl.bypass) begin
         d2_ff <= d1_ff;
         d1_ff <= w_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.start) begin
         x_ff <= sample_in;
      end
      if (ctrl.step == bqlp_pkg::ST_CHK) begin
         w_ff   <= w_in;
         bad_ff <= w_ovf;
      end
      if (ctrl.commit) begin
         out_ff     <= ctrl.bypass ? x_ff : y_sat;
         out_bad_ff <= ctrl.bypass ? 1'b0 : bad_ff;
      end
   end

   assign sample_out = out_ff;
   assign bad_value  = out_bad_ff;

endmodule

// ===== hdl/biquad_lowpass_filter_top.sv =====
// ----------------------------------------------------------------------------
// biquad_lowpass_filter_top
// Second-order low-pass IIR filter, direct form II, one channel.
//
// Samples arrive as beats on req_if and filtered samples leave as beats on
// rsp_if; both use valid/ready. Coefficients (Q2.14) and the enable bit are
// written through csr_we, csr_index and csr_wdata; the user must do so only
// while no sample is in flight, as the block does not enforce it. With the
// filter enabled, the five products of a sample go one after another through
// the single multiplier, along with the overflow check and rounding steps,
// and no new sample is taken until the result reaches the output register.
// With the filter disabled a sample skips those steps and goes straight to
// the output register, and the delay elements are kept. The output register
// holds one result, so a new sample is taken while the previous result still
// waits on rsp_if; if that result still waits when the next one is finished,
// the block holds the finished result and stops taking samples. Reset clears
// the coefficients, the enable bit, both delay elements and any pending result.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter_top #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16,
   parameter int STATE_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bqlp_req_if.sink                             req_if,
   bqlp_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [bqlp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [COEF_WIDTH-1:0]                csr_wdata
);

   logic                         enable;
   logic signed [COEF_WIDTH-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
   bqlp_pkg::ctrl_type           ctrl;

   bqlp_csr #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .enable    (enable),
      .coef_b0   (coef_b0),
      .coef_b1   (coef_b1),
      .coef_b2   (coef_b2),
      .coef_a1   (coef_a1),
      .coef_a2   (coef_a2)
   );

   bqlp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .enable    (enable),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .ctrl      (ctrl)
   );

   bqlp_dpath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH),
      .STATE_WIDTH  (STATE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample_in  (req_if.sample_in),
      .coef_b0    (coef_b0),
      .coef_b1    (coef_b1),
      .coef_b2    (coef_b2),
      .coef_a1    (coef_a1),
      .coef_a2    (coef_a2),
      .sample_out (rsp_if.sample_out),
      .bad_value  (rsp_if.bad_value)
   );

endmodule

// ===== tb/bqlp_response_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqlp_response_check
// Watches the sample channels and the register port of the biquad filter.
// It keeps its own copy of the coefficients and delay elements, works out the
// filtered sample and overflow flag for every accepted input beat, and
// compares each output beat with the oldest of those in arrival order.
// ----------------------------------------------------------------------------
module bqlp_response_check #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16,
   parameter int STATE_WIDTH  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   bqlp_req_if                                req,
   bqlp_rsp_if                                rsp,
   input  logic                               csr_we,
   input  logic [bqlp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_WIDTH-1:0]              csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);

   localparam int COEF_FRAC = COEF_WIDTH - 2;
   localparam int W_SHIFT   = COEF_FRAC;
   localparam int Y_SHIFT   = bqlp_pkg::STATE_FRAC + COEF_FRAC;
   localparam longint W_MAX = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
   localparam longint W_MIN = -W_MAX - 1;
   localparam longint Y_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint Y_MIN = -Y_MAX - 1;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           bad_value;
   } filter_result_type;

   filter_result_type               expected_results[$];
   logic                            enable_q;
   logic signed [COEF_WIDTH-1:0]    b0_q, b1_q, b2_q, a1_q, a2_q;
   longint                          delay_one, delay_two;
   int                              error_count = 0;
   int                              beat_count;

   assign mismatches = error_count;

   task automatic report_error(input string msg);
      $display("response check: %s", msg);
      error_count++;
   endtask

   // Direct form II step: the new internal value is rounded to the state
   // format, replaced by the scaled input on overflow, and shifted into the
   // delay line after the output is formed.
   function automatic filter_result_type filter_sample(
      input logic signed [SAMPLE_WIDTH-1:0] x);
      filter_result_type res;
      longint            acc;
      longint            w;
      longint            y;
      res.sample_out = x;
      res.bad_value  = 1'b0;
      if (!enable_q) begin
         return res;
      end
      acc = (longint'(x) <<< Y_SHIFT) - longint'(a1_q) * delay_one
            - longint'(a2_q) * delay_two;
      w = (acc + (longint'(1) <<< (W_SHIFT - 1))) >>> W_SHIFT;
      if (w > W_MAX || w < W_MIN) begin
         w = longint'(x) <<< bqlp_pkg::STATE_FRAC;
         res.bad_value = 1'b1;
      end
      acc = longint'(b0_q) * w + longint'(b1_q) * delay_one + longint'(b2_q) * delay_two;
      y = (acc + (longint'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT;
      if (y > Y_MAX) begin
         y = Y_MAX;
      end
      if (y < Y_MIN) begin
         y = Y_MIN;
      end
      res.sample_out = y[SAMPLE_WIDTH-1:0];
      delay_two = delay_one;
      delay_one = w;
      return res;
   endfunction

   always @(posedge clock) begin : sample_edge
      filter_result_type want;
      if (reset) begin
         enable_q  = 1'b0;
         b0_q      = '0;
         b1_q      = '0;
         b2_q      = '0;
         a1_q      = '0;
         a2_q      = '0;
         delay_one = 0;
         delay_two = 0;
         beat_count = 0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bqlp_pkg::REG_ENABLE: enable_q = csr_wdata[0];
               bqlp_pkg::REG_B0:     b0_q = csr_wdata;
               bqlp_pkg::REG_B1:     b1_q = csr_wdata;
               bqlp_pkg::REG_B2:     b2_q = csr_wdata;
               bqlp_pkg::REG_A1:     a1_q = csr_wdata;
               bqlp_pkg::REG_A2:     a2_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_error($sformatf("output beat %0d arrived with no sample in flight",
                                      beat_count));
            end else begin
               want = expected_results.pop_front();
               if (rsp.sample_out !== want.sample_out) begin
                  report_error($sformatf("beat %0d: sample_out %0d, expected %0d",
                                         beat_count, rsp.sample_out, want.sample_out));
               end
               if (rsp.bad_value !== want.bad_value) begin
                  report_error($sformatf("beat %0d: bad_value %b, expected %b",
                                         beat_count, rsp.bad_value, want.bad_value));
               end
            end
            beat_count++;
         end
         if (req.valid && req.ready) begin
            expected_results.push_back(filter_sample(req.sample_in));
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the biquad low-pass filter. After reset it runs a few
// directed sequences (pass-through at the extremes, a step into a stable
// filter, and a runaway filter that overflows its state), then many phases of
// random coefficients and samples with random sender gaps and receiver stalls
// (each off every fourth phase). A separate module predicts and checks output.
// ----------------------------------------------------------------------------
module tb;

   localparam int SW  = 16;
   localparam int CW  = 16;
   localparam int STW = 32;
   localparam int PHASES         = 14;
   localparam int BEATS_PER_PHASE = 125;
   localparam int LATENCY_MARGIN = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [bqlp_pkg::CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [bqlp_pkg::CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [CW-1:0] COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COEF_MIN   = {1'b1, {(CW-1){1'b0}}};

   typedef struct {
      logic                  en;
      logic signed [CW-1:0] b0, b1, b2, a1, a2;
   } coef_set_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we;
   logic [bqlp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [CW-1:0]                  csr_wdata;
   int                             mismatches;
   int                             outstanding;
   int                             idle_cycles = 0;
   int                             stall_left = 0;
   bit                             tx_gaps = 1'b1;
   bit                             rx_stalls = 1'b1;

   bqlp_req_if #(.SAMPLE_WIDTH(SW)) req_if ();
   bqlp_rsp_if #(.SAMPLE_WIDTH(SW)) rsp_if ();

   biquad_lowpass_filter_top #(
      .SAMPLE_WIDTH (SW),
      .COEF_WIDTH   (CW),
      .STATE_WIDTH  (STW)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bqlp_response_check #(
      .SAMPLE_WIDTH (SW),
      .COEF_WIDTH   (CW),
      .STATE_WIDTH  (STW)
   ) response_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin : receiver
      int n;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         n = rx_stalls ? gap_length() : 0;
         rsp_if.ready <= (n == 0);
         stall_left <= (n == 0) ? 0 : n - 1;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic coef_set_type lowpass_coefs(input int which);
      coef_set_type c;
      c.en = 1'b1;
      case (which)
         0: begin
            c.b0 = CW'(1106);  c.b1 = CW'(2212);  c.b2 = CW'(1106);
            c.a1 = CW'(-18727); c.a2 = CW'(6764);
         end
         1: begin
            c.b0 = CW'(4799);  c.b1 = CW'(9598);  c.b2 = CW'(4799);
            c.a1 = CW'(0);      c.a2 = CW'(2811);
         end
         default: begin
            c.b0 = CW'(59);    c.b1 = CW'(119);   c.b2 = CW'(59);
            c.a1 = CW'(-29863); c.a2 = CW'(13717);
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [CW-1:0] extreme_coef();
      case ($urandom_range(0, 2))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         default: return '0;
      endcase
   endfunction

   function automatic coef_set_type random_coefs();
      coef_set_type c;
      int           kind;
      kind = $urandom_range(0, 5);
      c = lowpass_coefs($urandom_range(0, 2));
      case (kind)
         2: begin
            c.b0 = CW'($urandom); c.b1 = CW'($urandom); c.b2 = CW'($urandom);
            c.a1 = CW'($urandom); c.a2 = CW'($urandom);
         end
         3: begin
            c.b0 = extreme_coef(); c.b1 = extreme_coef(); c.b2 = extreme_coef();
            c.a1 = extreme_coef(); c.a2 = extreme_coef();
         end
         4: begin
            c.b0 = CW'($urandom); c.b1 = CW'($urandom); c.b2 = CW'($urandom);
            c.a1 = CW'(int'($urandom_range(0, 16383)) - 8192);
            c.a2 = CW'(int'($urandom_range(0, 16383)) - 8192);
         end
         default: begin
            c.b0 += CW'(int'($urandom_range(0, 64)) - 32);
            c.b1 += CW'(int'($urandom_range(0, 64)) - 32);
            c.b2 += CW'(int'($urandom_range(0, 64)) - 32);
            c.a1 += CW'(int'($urandom_range(0, 64)) - 32);
            c.a2 += CW'(int'($urandom_range(0, 64)) - 32);
         end
      endcase
      c.en = (kind != 5);
      return c;
   endfunction

   function automatic logic signed [SW-1:0] random_sample(input logic signed [SW-1:0] last);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return SW'($urandom);
         5, 6:          return SW'(int'($urandom_range(0, 511)) - 256);
         7:             return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         default:       return last;
      endcase
   endfunction

   task automatic write_reg(input logic [bqlp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [CW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_coefs(input coef_set_type c);
      logic [CW-1:0] enable_word;
      enable_word    = CW'($urandom);
      enable_word[0] = c.en;
      write_reg(REG_UNUSED_LO, CW'($urandom));
      write_reg(REG_UNUSED_HI, CW'($urandom));
      write_reg(bqlp_pkg::REG_ENABLE, enable_word);
      write_reg(bqlp_pkg::REG_B0, c.b0);
      write_reg(bqlp_pkg::REG_B1, c.b1);
      write_reg(bqlp_pkg::REG_B2, c.b2);
      write_reg(bqlp_pkg::REG_A1, c.a1);
      write_reg(bqlp_pkg::REG_A2, c.a2);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [SW-1:0] x);
      int gap;
      bit drain;
      req_if.valid     <= 1'b1;
      req_if.sample_in <= x;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      drain = ($urandom_range(0, 149) == 0);
      gap = tx_gaps ? gap_length() : 0;
      if (drain && gap == 0) begin
         gap = 1;
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         while (drain && outstanding != 0) begin
            @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY_MARGIN) @(posedge clock);
   endtask

   initial begin
      coef_set_type          c;
      logic signed [SW-1:0]  x;
      req_if.valid     = 1'b0;
      req_if.sample_in = '0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The filter comes out of reset disabled, so these beats pass through.
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(SW'(-1));
      send_sample(SW'(1));

      settle();
      apply_coefs(lowpass_coefs(0));
      repeat (3) send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);

      // A filter with a pole far outside the unit circle drives the state
      // into overflow in both directions.
      settle();
      c.en = 1'b1;
      c.b0 = COEF_MAX; c.b1 = COEF_MAX; c.b2 = COEF_MAX;
      c.a1 = COEF_MIN; c.a2 = COEF_MIN;
      apply_coefs(c);
      repeat (6) send_sample(SAMPLE_MAX);
      repeat (6) send_sample(SAMPLE_MIN);

      x = '0;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         c = random_coefs();
         if (p == 0) begin
            c.en = 1'b1;
            c.b0 = COEF_MIN; c.b1 = COEF_MIN; c.b2 = COEF_MIN;
            c.a1 = COEF_MAX; c.a2 = COEF_MAX;
         end else if (p == 1) begin
            c.en = 1'b0;
         end else if (p == 2) begin
            c = lowpass_coefs(2);
         end
         tx_gaps   = (p % 4 != 1);
         rx_stalls = (p % 4 != 2);
         apply_coefs(c);
         repeat (BEATS_PER_PHASE) begin
            x = random_sample(x);
            send_sample(x);
         end
      end

      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      settle();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
